@@ sv/pat_pkg.sv @@
// Shared types, widths and codes of the pointer acceleration position tracker.
package pat_pkg;

  localparam int BUTTON_COUNT = 7;
  localparam int MAX_SCREEN   = 4096;

  localparam int ACTION_W = 2;
  localparam int DELTA_W  = 16;
  localparam int BIDX_W   = 4;
  localparam int REP_W    = 24;
  localparam int WHEEL_W  = 32;
  localparam int NUM_W    = 8;
  localparam int THR_W    = 15;
  localparam int BOUND_W  = 13;
  localparam int CFG_W    = 15;
  localparam int REG_IDX_W = 3;
  localparam int PROD_W   = 25;
  localparam int MAG_W    = 23;
  localparam int SUM_W    = 26;

  localparam logic [ACTION_W-1:0] ACT_MOVE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BUTTON = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WHEEL  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_NUMERATOR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DENOMINATOR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT      = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [NUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/pat_if.sv @@
// Event request and result channel interfaces of the pointer tracker.
interface pat_in_if;
  logic                          valid;
  logic                          ready;
  logic [pat_pkg::ACTION_W-1:0]  action;
  logic signed [pat_pkg::DELTA_W-1:0] move_dx;
  logic signed [pat_pkg::DELTA_W-1:0] move_dy;
  logic [pat_pkg::BIDX_W-1:0]    button_index;
  logic                          pressed;
  logic signed [pat_pkg::DELTA_W-1:0] wheel_delta;

  modport source (output valid, action, move_dx, move_dy, button_index, pressed,
                  wheel_delta, input ready);
  modport sink (input valid, action, move_dx, move_dy, button_index, pressed,
                wheel_delta, output ready);
endinterface

interface pat_out_if #(
  parameter int BUTTON_COUNT = pat_pkg::BUTTON_COUNT,
  parameter int POS_W        = $clog2(pat_pkg::MAX_SCREEN)
);
  logic                             valid;
  logic                             ready;
  logic signed [pat_pkg::REP_W-1:0] reported_dx;
  logic signed [pat_pkg::REP_W-1:0] reported_dy;
  logic [POS_W-1:0]                 pos_x;
  logic [POS_W-1:0]                 pos_y;
  logic [BUTTON_COUNT-1:0]          button_mask;
  logic signed [pat_pkg::WHEEL_W-1:0] wheel_total;
  logic                             accepted;

  modport source (output valid, reported_dx, reported_dy, pos_x, pos_y, button_mask,
                  wheel_total, accepted, input ready);
  modport sink (input valid, reported_dx, reported_dy, pos_x, pos_y, button_mask,
                wheel_total, accepted, output ready);
endinterface

@@ sv/pat_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module pat_div (
  input  logic              clk,
  input  logic              rst,
  input  pat_pkg::div_req_t req,
  output pat_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(pat_pkg::MAG_W + 1);

  logic                         busy;
  logic                         done;
  logic [CNT_W-1:0]             cnt;
  logic [pat_pkg::MAG_W-1:0]    dq;
  logic [pat_pkg::NUM_W-1:0]    rem;
  logic [pat_pkg::NUM_W-1:0]    divisor;
  logic [pat_pkg::NUM_W:0]      rem_shift;
  logic                         fits;
  logic [pat_pkg::NUM_W:0]      rem_sub;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    rem_shift = {rem, dq[pat_pkg::MAG_W-1]};
    fits      = rem_shift >= {1'b0, divisor};
    rem_sub   = rem_shift - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(pat_pkg::MAG_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq      <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      dq  <= {dq[pat_pkg::MAG_W-2:0], fits};
      rem <= fits ? rem_sub[pat_pkg::NUM_W-1:0] : rem_shift[pat_pkg::NUM_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

@@ sv/pointer_accel_position_tracker.sv @@
// Pointer tracker with threshold acceleration, clamped position, buttons and wheel.
//
// One event is taken at a time, and the request side is not ready while an event is
// being worked on. Button, wheel and reserved events go from the idle state straight
// to the update step, which loads the result register, and the next request can then
// be taken back in the idle state. A move runs the threshold test and multiply for
// each axis in turn, and each axis that is accelerated then goes through the shared
// restoring divider (23 quotient bits, one per cycle) before its result is written.
// The result sits in an output register, so the next request is taken while
// a finished result still waits; that request's update step then stalls until the
// waiting result is taken. Configuration writes go straight to the registers; a bound
// write re-clamps the matching coordinate in the same cycle.
module pointer_accel_position_tracker #(
  parameter int BUTTON_COUNT = pat_pkg::BUTTON_COUNT,
  parameter int MAX_SCREEN   = pat_pkg::MAX_SCREEN
) (
  input  logic                            clk,
  input  logic                            rst,
  pat_in_if.sink                          in_ch,
  pat_out_if.source                       out_ch,
  input  logic                            wr_en,
  input  logic [pat_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [pat_pkg::CFG_W-1:0]       wr_data
);

  localparam int POS_W = $clog2(MAX_SCREEN);
  localparam int LIM_W = POS_W + 1;
  localparam int DW    = pat_pkg::DELTA_W;
  localparam int RW    = pat_pkg::REP_W;
  localparam int SW    = pat_pkg::SUM_W;

  function automatic logic [LIM_W-1:0] eff_bound(input logic [pat_pkg::BOUND_W-1:0] b);
    logic [LIM_W-1:0] r;
    if (b == '0) begin
      r = LIM_W'(1);
    end else if (32'(b) > MAX_SCREEN) begin
      r = LIM_W'(MAX_SCREEN);
    end else begin
      r = LIM_W'(b);
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SW-1:0] p,
                                                 input logic [pat_pkg::BOUND_W-1:0] b);
    logic [LIM_W-1:0]     lim;
    logic [LIM_W-1:0]     top;
    logic [POS_W-1:0]     r;
    lim = eff_bound(b);
    top = lim - LIM_W'(1);
    if (p < 0) begin
      r = '0;
    end else if (p >= $signed({{(SW-LIM_W){1'b0}}, lim})) begin
      r = top[POS_W-1:0];
    end else begin
      r = p[POS_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [pat_pkg::NUM_W-1:0]   gain_num;
  logic [pat_pkg::NUM_W-1:0]   gain_den;
  logic [pat_pkg::THR_W-1:0]   accel_threshold;
  logic [pat_pkg::BOUND_W-1:0] bound_x;
  logic [pat_pkg::BOUND_W-1:0] bound_y;

  // Architectural state.
  logic [POS_W-1:0]              position_x;
  logic [POS_W-1:0]              position_y;
  logic [BUTTON_COUNT-1:0]       held_buttons;
  logic [pat_pkg::WHEEL_W-1:0]   wheel_accum;

  // Latched request.
  logic [pat_pkg::ACTION_W-1:0]  ev_action;
  logic signed [DW-1:0]          ev_dx;
  logic signed [DW-1:0]          ev_dy;
  logic [pat_pkg::BIDX_W-1:0]    ev_index;
  logic                          ev_pressed;
  logic signed [DW-1:0]          ev_wheel;

  pat_pkg::state_t state, state_next;
  logic            sel;
  logic            prod_neg_hold;
  logic signed [RW-1:0] rdx;
  logic signed [RW-1:0] rdy;
  logic            out_valid;

  pat_pkg::div_req_t div_req;
  pat_pkg::div_rsp_t div_rsp;
  logic              div_start;

  logic                        in_take;
  logic                        axis_wr;
  logic                        out_load;
  logic signed [RW-1:0]        axis_val;
  logic signed [DW-1:0]        axis_d;
  logic [DW:0]                 axis_mag;
  logic                        accel_on;
  logic                        apply;
  logic signed [pat_pkg::PROD_W-1:0] prod;
  logic [pat_pkg::PROD_W-1:0]  prod_abs;
  logic [RW-1:0]               quot_ext;

  logic signed [SW-1:0]        sum_x;
  logic signed [SW-1:0]        sum_y;
  logic [POS_W-1:0]            upd_x;
  logic [POS_W-1:0]            upd_y;
  logic [BUTTON_COUNT-1:0]     upd_buttons;
  logic [BUTTON_COUNT-1:0]     bit_sel;
  logic [pat_pkg::WHEEL_W-1:0] upd_wheel;
  logic                        upd_ok;

  pat_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Axis datapath: threshold test, multiply and sign handling around the divider.
  always_comb begin
    axis_d   = sel ? ev_dy : ev_dx;
    axis_mag = axis_d[DW-1] ? -{axis_d[DW-1], axis_d} : {axis_d[DW-1], axis_d};
    accel_on = (gain_num != '0) && (gain_den != '0);
    apply    = accel_on && (axis_mag > (DW+1)'(accel_threshold));
    prod     = $signed({{(pat_pkg::PROD_W-DW){axis_d[DW-1]}}, axis_d}) *
               $signed({{(pat_pkg::PROD_W-pat_pkg::NUM_W){1'b0}}, gain_num});
    prod_abs = prod[pat_pkg::PROD_W-1] ? -prod : prod;
    quot_ext = {{(RW-pat_pkg::MAG_W){1'b0}}, div_rsp.quotient};
    div_req.start    = div_start;
    div_req.dividend = prod_abs[pat_pkg::MAG_W-1:0];
    div_req.divisor  = gain_den;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_take    = 1'b0;
    axis_wr    = 1'b0;
    axis_val   = {{(RW-DW){axis_d[DW-1]}}, axis_d};
    out_load   = 1'b0;
    div_start  = 1'b0;
    case (state)
      pat_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          in_take    = 1'b1;
          state_next = (in_ch.action == pat_pkg::ACT_MOVE) ? pat_pkg::S_MUL
                                                            : pat_pkg::S_UPDATE;
        end
      end
      pat_pkg::S_MUL: begin
        if (apply) begin
          div_start  = 1'b1;
          state_next = pat_pkg::S_DIV;
        end else begin
          axis_wr    = 1'b1;
          state_next = sel ? pat_pkg::S_UPDATE : pat_pkg::S_MUL;
        end
      end
      pat_pkg::S_DIV: begin
        axis_val = prod_neg_hold ? -quot_ext : quot_ext;
        if (div_rsp.done) begin
          axis_wr    = 1'b1;
          state_next = sel ? pat_pkg::S_UPDATE : pat_pkg::S_MUL;
        end
      end
      pat_pkg::S_UPDATE: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = pat_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pat_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ch.ready = (state == pat_pkg::S_IDLE);

  // State update for the finished event.
  always_comb begin
    sum_x       = $signed({{(SW-POS_W){1'b0}}, position_x}) + $signed(SW'(rdx));
    sum_y       = $signed({{(SW-POS_W){1'b0}}, position_y}) + $signed(SW'(rdy));
    upd_x       = position_x;
    upd_y       = position_y;
    upd_buttons = held_buttons;
    upd_wheel   = wheel_accum;
    upd_ok      = 1'b1;
    bit_sel     = BUTTON_COUNT'(1) << ev_index;
    case (ev_action)
      pat_pkg::ACT_MOVE: begin
        upd_x = clamp_pos(sum_x, bound_x);
        upd_y = clamp_pos(sum_y, bound_y);
      end
      pat_pkg::ACT_BUTTON: begin
        if (32'(ev_index) < BUTTON_COUNT) begin
          upd_buttons = ev_pressed ? (held_buttons | bit_sel) : (held_buttons & ~bit_sel);
        end else begin
          upd_ok = 1'b0;
        end
      end
      pat_pkg::ACT_WHEEL: begin
        upd_wheel = wheel_accum + {{(pat_pkg::WHEEL_W-DW){ev_wheel[DW-1]}}, ev_wheel};
      end
      default: begin
        upd_ok = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        sel <= 1'b0;
      end else if (axis_wr) begin
        sel <= ~sel;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Configuration and tracked state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_num        <= '0;
      gain_den        <= pat_pkg::NUM_W'(1);
      accel_threshold <= pat_pkg::THR_W'(4);
      bound_x         <= pat_pkg::BOUND_W'(1024);
      bound_y         <= pat_pkg::BOUND_W'(768);
      position_x      <= '0;
      position_y      <= '0;
      held_buttons    <= '0;
      wheel_accum     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        pat_pkg::REG_NUMERATOR: begin
          gain_num <= wr_data[pat_pkg::NUM_W-1:0];
        end
        pat_pkg::REG_DENOMINATOR: begin
          gain_den <= wr_data[pat_pkg::NUM_W-1:0];
        end
        pat_pkg::REG_THRESHOLD: begin
          accel_threshold <= wr_data[pat_pkg::THR_W-1:0];
        end
        pat_pkg::REG_WIDTH: begin
          bound_x    <= wr_data[pat_pkg::BOUND_W-1:0];
          position_x <= clamp_pos($signed({{(SW-POS_W){1'b0}}, position_x}),
                                  wr_data[pat_pkg::BOUND_W-1:0]);
        end
        pat_pkg::REG_HEIGHT: begin
          bound_y    <= wr_data[pat_pkg::BOUND_W-1:0];
          position_y <= clamp_pos($signed({{(SW-POS_W){1'b0}}, position_y}),
                                  wr_data[pat_pkg::BOUND_W-1:0]);
        end
        default: begin
        end
      endcase
    end else if (out_load) begin
      position_x   <= upd_x;
      position_y   <= upd_y;
      held_buttons <= upd_buttons;
      wheel_accum  <= upd_wheel;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_action  <= in_ch.action;
      ev_dx      <= in_ch.move_dx;
      ev_dy      <= in_ch.move_dy;
      ev_index   <= in_ch.button_index;
      ev_pressed <= in_ch.pressed;
      ev_wheel   <= in_ch.wheel_delta;
      rdx        <= '0;
      rdy        <= '0;
    end else if (axis_wr) begin
      if (sel) begin
        rdy <= axis_val;
      end else begin
        rdx <= axis_val;
      end
    end
    if (div_start) begin
      prod_neg_hold <= prod[pat_pkg::PROD_W-1];
    end
    if (out_load) begin
      out_ch.reported_dx <= rdx;
      out_ch.reported_dy <= rdy;
      out_ch.pos_x       <= upd_x;
      out_ch.pos_y       <= upd_y;
      out_ch.button_mask <= upd_buttons;
      out_ch.wheel_total <= upd_wheel;
      out_ch.accepted    <= upd_ok;
    end
  end

  assign out_ch.valid = out_valid;

  // The divider is started only from the multiply step and answers only while awaited.
  assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == pat_pkg::S_MUL))
    else $error("divider started outside the multiply step");

  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == pat_pkg::S_DIV))
    else $error("divider finished while not awaited");

  // The tracked position always lies inside the current bounds.
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, position_x} < eff_bound(bound_x)) &&
    ({1'b0, position_y} < eff_bound(bound_y)))
    else $error("position outside the screen bounds");

  // Only one event is in flight: no request is taken right after another.
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request taken while an event is in flight");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the pointer tracker: random and directed events against a predictor.
module testbench;

  localparam logic [pat_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int POS_W = $clog2(pat_pkg::MAX_SCREEN);
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [pat_pkg::ACTION_W-1:0]       action;
    logic signed [pat_pkg::DELTA_W-1:0] dx;
    logic signed [pat_pkg::DELTA_W-1:0] dy;
    logic [pat_pkg::BIDX_W-1:0]         bidx;
    logic                               pressed;
    logic signed [pat_pkg::DELTA_W-1:0] wheel;
  } pointer_event_t;

  typedef struct {
    logic signed [pat_pkg::REP_W-1:0] dx;
    logic signed [pat_pkg::REP_W-1:0] dy;
    logic [POS_W-1:0]                 px;
    logic [POS_W-1:0]                 py;
    logic [pat_pkg::BUTTON_COUNT-1:0] mask;
    logic [pat_pkg::WHEEL_W-1:0]      wheel;
    logic                             ok;
  } pointer_report_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [pat_pkg::REG_IDX_W-1:0] wr_index;
  logic [pat_pkg::CFG_W-1:0] wr_data;

  pat_in_if in_ch ();
  pat_out_if out_ch ();

  pointer_accel_position_tracker DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // Predicted state of the tracker and its registers.
  int cur_x, cur_y;
  logic [pat_pkg::BUTTON_COUNT-1:0] held;
  logic [pat_pkg::WHEEL_W-1:0] wheel_sum;
  int numer, denom, thresh, bound_w, bound_h;

  pointer_report_t pending_reports[$];
  int mismatch_count;
  bit no_idle;

  always #4 clk = ~clk;

  function automatic int effective_bound(int b);
    if (b == 0) return 1;
    if (b > pat_pkg::MAX_SCREEN) return pat_pkg::MAX_SCREEN;
    return b;
  endfunction

  function automatic int clamp_coord(int p, int b);
    int lim;
    lim = effective_bound(b);
    if (p < 0) return 0;
    if (p >= lim) return lim - 1;
    return p;
  endfunction

  // Integer division on int truncates toward zero, as the hardware must.
  function automatic int accelerate(int d);
    if (numer == 0 || denom == 0) return d;
    if (d > thresh || d < -thresh) return (d * numer) / denom;
    return d;
  endfunction

  function automatic pointer_report_t predict_report(pointer_event_t ev);
    pointer_report_t r;
    int sx, sy;
    sx = 0;
    sy = 0;
    r.ok = 1'b1;
    case (ev.action)
      pat_pkg::ACT_MOVE: begin
        sx = accelerate(int'(ev.dx));
        sy = accelerate(int'(ev.dy));
        cur_x = clamp_coord(cur_x + sx, bound_w);
        cur_y = clamp_coord(cur_y + sy, bound_h);
      end
      pat_pkg::ACT_BUTTON: begin
        if (ev.bidx < pat_pkg::BUTTON_COUNT) held[ev.bidx] = ev.pressed;
        else r.ok = 1'b0;
      end
      pat_pkg::ACT_WHEEL: begin
        wheel_sum = wheel_sum +
                    {{(pat_pkg::WHEEL_W - pat_pkg::DELTA_W){ev.wheel[pat_pkg::DELTA_W-1]}},
                     ev.wheel};
      end
      default: r.ok = 1'b0;
    endcase
    r.dx = sx[pat_pkg::REP_W-1:0];
    r.dy = sy[pat_pkg::REP_W-1:0];
    r.px = cur_x[POS_W-1:0];
    r.py = cur_y[POS_W-1:0];
    r.mask = held;
    r.wheel = wheel_sum;
    return r;
  endfunction

  function automatic void apply_register(logic [pat_pkg::REG_IDX_W-1:0] idx, int value);
    case (idx)
      pat_pkg::REG_NUMERATOR: numer = value & 'hFF;
      pat_pkg::REG_DENOMINATOR: denom = value & 'hFF;
      pat_pkg::REG_THRESHOLD: thresh = value & 'h7FFF;
      pat_pkg::REG_WIDTH, pat_pkg::REG_HEIGHT: begin
        if (idx == pat_pkg::REG_WIDTH) bound_w = value & 'h1FFF;
        else bound_h = value & 'h1FFF;
        cur_x = clamp_coord(cur_x, bound_w);
        cur_y = clamp_coord(cur_y, bound_h);
      end
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Mixes deltas near the threshold, small deltas, full-range values, zero and the extremes.
  function automatic logic signed [pat_pkg::DELTA_W-1:0] random_delta();
    logic signed [pat_pkg::DELTA_W-1:0] v;
    int sel, mag;
    sel = $urandom_range(0, 9);
    v = pat_pkg::DELTA_W'($urandom);
    if (sel < 4) begin
      mag = $urandom_range(0, (thresh < 32760 ? thresh : 32760) + 3);
      v = pat_pkg::DELTA_W'($urandom_range(0, 1) ? -mag : mag);
    end else if (sel == 8) begin
      mag = $urandom_range(0, 300);
      v = pat_pkg::DELTA_W'($urandom_range(0, 1) ? -mag : mag);
    end else if (sel == 9) begin
      case ($urandom_range(0, 2))
        0: v = 16'sh8000;
        1: v = 16'sh7FFF;
        default: v = 16'sh0000;
      endcase
    end
    return v;
  endfunction

  function automatic pointer_event_t random_event();
    pointer_event_t ev;
    int r;
    r = $urandom_range(0, 99);
    ev.dx = random_delta();
    ev.dy = random_delta();
    ev.bidx = pat_pkg::BIDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                               : $urandom_range(0, pat_pkg::BUTTON_COUNT - 1));
    ev.pressed = 1'($urandom_range(0, 1));
    ev.wheel = pat_pkg::DELTA_W'($urandom);
    if (r < 55) ev.action = pat_pkg::ACT_MOVE;
    else if (r < 75) ev.action = pat_pkg::ACT_BUTTON;
    else if (r < 93) ev.action = pat_pkg::ACT_WHEEL;
    else ev.action = ACT_RESERVED;
    return ev;
  endfunction

  task automatic send_event(pointer_event_t ev);
    int gap;
    gap = no_idle ? 0 : gap_len();
    repeat (gap) @(negedge clk) in_ch.valid = 1'b0;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.action = ev.action;
    in_ch.move_dx = ev.dx;
    in_ch.move_dy = ev.dy;
    in_ch.button_index = ev.bidx;
    in_ch.pressed = ev.pressed;
    in_ch.wheel_delta = ev.wheel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_reports.push_back(predict_report(ev));
  endtask

  task automatic send_move(int dx, int dy);
    pointer_event_t ev;
    ev = random_event();
    ev.action = pat_pkg::ACT_MOVE;
    ev.dx = pat_pkg::DELTA_W'(dx);
    ev.dy = pat_pkg::DELTA_W'(dy);
    send_event(ev);
  endtask

  task automatic send_button(int idx, bit down);
    pointer_event_t ev;
    ev = random_event();
    ev.action = pat_pkg::ACT_BUTTON;
    ev.bidx = pat_pkg::BIDX_W'(idx);
    ev.pressed = down;
    send_event(ev);
  endtask

  task automatic send_wheel(int delta);
    pointer_event_t ev;
    ev = random_event();
    ev.action = pat_pkg::ACT_WHEEL;
    ev.wheel = pat_pkg::DELTA_W'(delta);
    send_event(ev);
  endtask

  // Registers change only once every outstanding request has produced its result.
  task automatic write_register(logic [pat_pkg::REG_IDX_W-1:0] idx, int value);
    @(negedge clk) in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = pat_pkg::CFG_W'(value);
    apply_register(idx, value);
    @(negedge clk) wr_en = 1'b0;
  endtask

  task automatic configure(int num, int den, int thr, int w, int h);
    write_register(pat_pkg::REG_NUMERATOR, num);
    write_register(pat_pkg::REG_DENOMINATOR, den);
    write_register(pat_pkg::REG_THRESHOLD, thr);
    write_register(pat_pkg::REG_WIDTH, w);
    write_register(pat_pkg::REG_HEIGHT, h);
  endtask

  task automatic test_reset_defaults();
    send_move(2000, 900);
    send_move(-7, -3);
  endtask

  task automatic test_acceleration();
    configure(3, 2, 4, 1024, 768);
    send_move(4, -4);
    send_move(5, -5);
    send_move(32767, -32768);
    send_move(-32768, 32767);
    send_move(0, 0);
    configure(255, 1, 0, 4096, 4096);
    send_move(-32768, 32767);
    write_register(pat_pkg::REG_DENOMINATOR, 0);
    send_move(100, 100);
  endtask

  task automatic test_buttons();
    send_button(0, 1'b1);
    send_button(pat_pkg::BUTTON_COUNT - 1, 1'b1);
    send_button(0, 1'b0);
    send_button(pat_pkg::BUTTON_COUNT, 1'b1);
    send_button(15, 1'b1);
    send_button(pat_pkg::BUTTON_COUNT - 1, 1'b0);
  endtask

  task automatic test_wheel();
    send_wheel(32767);
    send_wheel(-32768);
    send_wheel(1);
  endtask

  task automatic test_reserved_action();
    pointer_event_t ev;
    repeat (2) begin
      ev = random_event();
      ev.action = ACT_RESERVED;
      send_event(ev);
    end
  endtask

  // A zero bound pins the coordinate at 0; a bound above the screen limit saturates.
  task automatic test_bounds();
    configure(0, 1, 4, 8191, 8191);
    send_move(32767, 32767);
    write_register(pat_pkg::REG_WIDTH, 0);
    write_register(pat_pkg::REG_HEIGHT, 1000);
    send_move(-5, 3);
    write_register(pat_pkg::REG_WIDTH, 1);
    write_register(pat_pkg::REG_HEIGHT, 0);
    send_move(300, 300);
    write_register(pat_pkg::REG_WIDTH, pat_pkg::MAX_SCREEN);
    write_register(pat_pkg::REG_HEIGHT, pat_pkg::MAX_SCREEN);
    send_move(100, -20000);
  endtask

  task automatic run_phase(int num, int den, int thr, int w, int h, int count, bit steady);
    configure(num, den, thr, w, h);
    no_idle = steady;
    repeat (count) send_event(random_event());
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(0, 1, 4, 1024, 768, 120, 1'b0);
    run_phase(3, 2, 4, 1024, 768, 120, 1'b1);
    run_phase(255, 1, 0, 4096, 4096, 120, 1'b0);
    run_phase(1, 255, 32767, 1, 1, 100, 1'b0);
    run_phase(7, 3, 100, 0, 8191, 120, 1'b1);
    run_phase(128, 0, 10, 640, 480, 100, 1'b0);
    repeat (3) begin
      run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 64),
                $urandom_range(0, 8191), $urandom_range(0, 8191), 110,
                $urandom_range(0, 3) == 0);
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_reports
    pointer_report_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual pos %0d,%0d mask 0x%0h",
                 $time, out_ch.pos_x, out_ch.pos_y, out_ch.button_mask);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("reported_dx", 32'(want.dx), 32'(out_ch.reported_dx));
        compare_field("reported_dy", 32'(want.dy), 32'(out_ch.reported_dy));
        compare_field("pos_x", 32'(want.px), 32'(out_ch.pos_x));
        compare_field("pos_y", 32'(want.py), 32'(out_ch.pos_y));
        compare_field("button_mask", 32'(want.mask), 32'(out_ch.button_mask));
        compare_field("wheel_total", want.wheel, out_ch.wheel_total);
        compare_field("accepted", 32'(want.ok), 32'(out_ch.accepted));
      end
    end
  end

  // Result side: random stalls, none while a steady phase runs.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0 && !no_idle) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        stall = (no_idle || $urandom_range(0, 2) != 0) ? 0 : gap_len();
      end
    end
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = pat_pkg::ACT_MOVE;
    in_ch.move_dx = '0;
    in_ch.move_dy = '0;
    in_ch.button_index = '0;
    in_ch.pressed = 1'b0;
    in_ch.wheel_delta = '0;
    mismatch_count = 0;
    no_idle = 1'b0;
    numer = 0;
    denom = 1;
    thresh = 4;
    bound_w = 1024;
    bound_h = 768;
    cur_x = 0;
    cur_y = 0;
    held = '0;
    wheel_sum = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_acceleration();
    test_buttons();
    test_wheel();
    test_reserved_action();
    test_bounds();
    test_random_traffic();

    @(negedge clk) in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
